// File: sv/jdn_pkg.sv
// Package for the joystick dead zone normalizer: item types, register codes,
// reset values and sequencer states.
// No dependencies; used by the top level and its checker.
package jdn_pkg;

    localparam int NUM_CONTROLLERS = 4;

    localparam logic [1:0] CFG_INNER = 2'd0;
    localparam logic [1:0] CFG_OUTER = 2'd1;
    localparam logic [1:0] CFG_START = 2'd2;

    localparam logic [3:0] INNER_RESET = 4'd6;
    localparam logic [3:0] OUTER_RESET = 4'd10;
    localparam logic [6:0] START_RESET = 7'd64;

    localparam logic [14:0] ONE_Q14    = 15'd16384;
    localparam logic [29:0] ONE_SQ     = 30'h1000_0000;
    localparam logic [4:0]  DIV_STEPS  = 5'd23;
    localparam logic [4:0]  ROOT_STEPS = 5'd23;
    localparam logic [4:0]  NORM_STEPS = 5'd16;

    typedef struct packed {
        logic [1:0]        controller;
        logic              no_controller;
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
    } t_out_item;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_PREP = 11'b000_0000_0010,
        S_DIVX = 11'b000_0000_0100,
        S_DIVY = 11'b000_0000_1000,
        S_SQX  = 11'b000_0001_0000,
        S_SQY  = 11'b000_0010_0000,
        S_CHK  = 11'b000_0100_0000,
        S_ROOT = 11'b000_1000_0000,
        S_RNX  = 11'b001_0000_0000,
        S_RNY  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

endpackage

// File: sv/joystick_deadzone_normalizer.sv
// Joystick dead zone normalizer: range tracking, dead zones, scaling and
// radial renormalization on one shared subtract/compare unit.
// Depends on jdn_pkg.
// No new input is taken until the item's result is registered at the output,
// and a result still stalled there holds the next one back; an absent
// controller goes straight to the result. The sequencer runs two 23-step divisions
// and, when the vector is renormalized, a 23-step square root and two 16-step divisions.
// Reset (synchronous, active low) restores register defaults and loads the
// start range into every controller's tracked range.
module joystick_deadzone_normalizer import jdn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    t_state      r_state;
    logic [3:0]  r_inner, r_outer;
    logic [7:0]  r_range [NUM_CONTROLLERS];
    t_in_item    r_item;
    logic        r_sx, r_sy;
    logic [7:0]  r_magy, r_d;
    logic [14:0] r_qx, r_qy;
    logic [29:0] r_m;
    logic [24:0] r_rem;
    logic [36:0] r_num;
    logic [22:0] r_quo, r_den;
    logic [4:0]  r_cnt;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [24:0] n_rem;
    logic [36:0] n_num;
    logic [22:0] n_quo;

    function automatic logic signed [8:0] dead(input logic signed [7:0] v,
                                               input logic [3:0] dz);
        logic signed [8:0] ve, de;
        ve = 9'(v);
        de = $signed({5'b0, dz});
        if (ve > 0) return (ve < de) ? 9'sd0 : ve - de;
        return (ve > -de) ? 9'sd0 : ve + de;
    endfunction

    function automatic logic [7:0] abs8(input logic signed [7:0] v);
        logic signed [8:0] ve;
        ve = 9'(v);
        return ve[8] ? 8'(-ve) : ve[7:0];
    endfunction

    function automatic logic [22:0] scale_num(input logic [7:0] mag,
                                              input logic [7:0] d);
        return {mag, 15'b0} + {15'b0, d};
    endfunction

    function automatic logic [14:0] clampq(input logic [22:0] q);
        return (q > {8'b0, ONE_Q14}) ? ONE_Q14 : q[14:0];
    endfunction

    function automatic logic [15:0] apply_sign(input logic [14:0] q, input logic s);
        logic [15:0] m;
        m = {1'b0, q};
        return s ? -m : m;
    endfunction

    function automatic logic [36:0] norm_num(input logic [14:0] q, input logic [22:0] s);
        return {q, 22'b0} + {15'b0, s[22:1]};
    endfunction

    // Front end: range widening, dead zones and divisor.
    logic              in_acc, absent;
    logic [7:0]        ax, ay, cur, wid;
    logic signed [8:0] dx, dy;
    logic signed [9:0] dlt;
    logic [7:0]        dv, magx, magy;

    always_comb begin
        in_acc = i_valid && !o_stall;
        absent = i_data.no_controller || (int'(i_data.controller) >= NUM_CONTROLLERS);
        ax  = abs8(r_item.stick_x);
        ay  = abs8(r_item.stick_y);
        cur = r_range[r_item.controller];
        wid = cur;
        if (ax > wid) wid = ax;
        if (ay > wid) wid = ay;
        dx  = dead(r_item.stick_x, r_inner);
        dy  = dead(r_item.stick_y, r_inner);
        dlt = $signed({2'b0, wid}) - $signed({6'b0, r_inner}) - $signed({6'b0, r_outer});
        dv  = (dlt < 10'sd1) ? 8'd1 : dlt[7:0];
        magx = dx[8] ? 8'(-dx) : dx[7:0];
        magy = dy[8] ? 8'(-dy) : dy[7:0];
    end

    // Shared subtract/compare unit: one restoring divide or root step a cycle.
    logic [25:0] sub_a, sub_b;
    logic [26:0] diff;
    logic        ge;
    logic [14:0] mul_a;
    logic [29:0] prod;
    logic [36:0] nrm_x, nrm_y;

    always_comb begin
        if (r_state == S_ROOT) begin
            sub_a = {r_rem[23:0], r_num[36:35]};
            sub_b = {1'b0, r_quo, 2'b01};
            n_num = r_num << 2;
        end else begin
            sub_a = {r_rem, r_num[36]};
            sub_b = {3'b0, r_den};
            n_num = r_num << 1;
        end
        diff  = {1'b0, sub_a} - {1'b0, sub_b};
        ge    = !diff[26];
        n_rem = ge ? diff[24:0] : sub_a[24:0];
        n_quo = {r_quo[21:0], ge};
        mul_a = (r_state == S_SQX) ? r_qx : r_qy;
        prod  = {15'b0, mul_a} * {15'b0, mul_a};
        nrm_x = norm_num(r_qx, n_quo);
        nrm_y = norm_num(r_qy, r_den);
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_inner     <= INNER_RESET;
            r_outer     <= OUTER_RESET;
            for (int i = 0; i < NUM_CONTROLLERS; i++) r_range[i] <= {1'b0, START_RESET};
        end else begin
            if (r_out_valid && !i_stall && r_state != S_DONE) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item <= i_data;
                        if (absent) begin
                            r_qx    <= '0;
                            r_qy    <= '0;
                            r_sx    <= 1'b0;
                            r_sy    <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_range[r_item.controller] <= wid;
                    r_sx    <= dx[8];
                    r_sy    <= (dy > 9'sd0);
                    r_magy  <= magy;
                    r_d     <= dv;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_num   <= {scale_num(magx, dv), 14'b0};
                    r_den   <= {14'b0, dv, 1'b0};
                    r_cnt   <= DIV_STEPS;
                    r_state <= S_DIVX;
                end
                S_DIVX, S_DIVY, S_ROOT, S_RNX, S_RNY: begin
                    if (r_cnt != 5'd1) begin
                        r_rem <= n_rem;
                        r_quo <= n_quo;
                        r_num <= n_num;
                        r_cnt <= r_cnt - 5'd1;
                    end else begin
                        r_quo <= '0;
                        case (r_state)
                            S_DIVX: begin
                                r_rem   <= '0;
                                r_qx    <= clampq(n_quo);
                                r_num   <= {scale_num(r_magy, r_d), 14'b0};
                                r_cnt   <= DIV_STEPS;
                                r_state <= S_DIVY;
                            end
                            S_DIVY: begin
                                r_qy    <= clampq(n_quo);
                                r_state <= S_SQX;
                            end
                            S_ROOT: begin
                                // The quotient fits in 16 bits, so the upper
                                // numerator bits start out as the remainder.
                                r_rem   <= {4'b0, nrm_x[36:16]};
                                r_num   <= {nrm_x[15:0], 21'b0};
                                r_den   <= n_quo;
                                r_cnt   <= NORM_STEPS;
                                r_state <= S_RNX;
                            end
                            S_RNX: begin
                                r_qx    <= clampq(n_quo);
                                r_rem   <= {4'b0, nrm_y[36:16]};
                                r_num   <= {nrm_y[15:0], 21'b0};
                                r_cnt   <= NORM_STEPS;
                                r_state <= S_RNY;
                            end
                            default: begin
                                r_qy    <= clampq(n_quo);
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SQX: begin
                    r_m     <= prod;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_m     <= r_m + prod;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_m > ONE_SQ) begin
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_num   <= {r_m, 7'b0};
                        r_cnt   <= ROOT_STEPS;
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out.axis_x <= apply_sign(r_qx, r_sx);
                        r_out.axis_y <= apply_sign(r_qy, r_sy);
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INNER: r_inner <= i_cfg_data[3:0];
                    CFG_OUTER: r_outer <= i_cfg_data[3:0];
                    CFG_START: begin
                        for (int i = 0; i < NUM_CONTROLLERS; i++) r_range[i] <= {1'b0, i_cfg_data};
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: sv/jdn_checker.sv
// Port-level checker for the joystick dead zone normalizer, bound to the top.
// Depends on jdn_pkg.
module jdn_checker import jdn_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input t_in_item  i_data,
    input logic      o_stall,
    input logic      o_valid,
    input t_out_item o_data,
    input logic      i_stall
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // An input transfer makes the block busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after input transfer");

    // Results are within plus and minus one.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.axis_x <= 16'sd16384 && o_data.axis_x >= -16'sd16384 &&
                    o_data.axis_y <= 16'sd16384 && o_data.axis_y >= -16'sd16384)
        else $error("result out of range");

    // A new result only appears at the end of an item's work.
    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without work in progress");

endmodule

bind joystick_deadzone_normalizer jdn_checker u_jdn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_data  (i_data),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);

// File: dv/joystick_deadzone_normalizer_tb.sv
// Testbench for the joystick dead zone normalizer: directed and random stick
// samples under random idling, checked against an internal fixed-point predictor.
// Depends on jdn_pkg and the joystick_deadzone_normalizer top level.
`timescale 1ns / 100ps

module joystick_deadzone_normalizer_tb;
    import jdn_pkg::*;

    class axis_scoreboard;
        t_out_item expected_axes[$];
        int        error_count;
        logic [3:0] inner_dz;
        logic [3:0] outer_dz;
        logic [6:0] start_rng;
        int         tracked[NUM_CONTROLLERS];

        function new();
            error_count = 0;
            inner_dz = INNER_RESET;
            outer_dz = OUTER_RESET;
            start_rng = START_RESET;
            foreach (tracked[i]) tracked[i] = START_RESET;
        endfunction

        function void write_register(logic [1:0] index, logic [6:0] data);
            case (index)
                CFG_INNER: inner_dz = data[3:0];
                CFG_OUTER: outer_dz = data[3:0];
                CFG_START: begin
                    start_rng = data;
                    foreach (tracked[i]) tracked[i] = data;
                end
                default: ;
            endcase
        endfunction

        function int apply_dead_zone(int v);
            int dz;
            dz = inner_dz;
            if (v > 0) return (v < dz) ? 0 : v - dz;
            return (v > -dz) ? 0 : v + dz;
        endfunction

        function int scale_to_q14(int r, int d);
            longint mag;
            longint q;
            mag = (r < 0) ? -r : r;
            q = (mag * 16384 * 2 + d) / (2 * d);
            if (q > 16384) q = 16384;
            return (r < 0) ? -int'(q) : int'(q);
        endfunction

        function longint int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function int unit_rescale(int a, longint s);
            longint mag;
            longint q;
            mag = (a < 0) ? -a : a;
            q = ((mag << 22) + s / 2) / s;
            if (q > 16384) q = 16384;
            return (a < 0) ? -int'(q) : int'(q);
        endfunction

        function void note_sample(t_in_item it);
            t_out_item res;
            int rx, ry, d, x, y, c;
            longint m, s;
            res = '0;
            c = it.controller;
            if (!it.no_controller && c < NUM_CONTROLLERS) begin
                rx = it.stick_x;
                ry = it.stick_y;
                // The range widens to the largest magnitude on either axis.
                if (rx > tracked[c]) tracked[c] = rx;
                else if (rx < -tracked[c]) tracked[c] = -rx;
                if (ry > tracked[c]) tracked[c] = ry;
                else if (ry < -tracked[c]) tracked[c] = -ry;
                rx = apply_dead_zone(rx);
                ry = apply_dead_zone(ry);
                d = tracked[c] - int'(outer_dz) - int'(inner_dz);
                if (d < 1) d = 1;
                x = scale_to_q14(rx, d);
                y = scale_to_q14(-ry, d);
                m = longint'(x) * x + longint'(y) * y;
                if (m > (64'd1 << 28)) begin
                    s = int_sqrt(m << 16);
                    x = unit_rescale(x, s);
                    y = unit_rescale(y, s);
                end
                res.axis_x = x[15:0];
                res.axis_y = y[15:0];
            end
            expected_axes.push_back(res);
        endfunction

        function void check_axes(t_out_item got);
            t_out_item exp_item;
            if (expected_axes.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, got.axis_x, got.axis_y);
                error_count++;
                return;
            end
            exp_item = expected_axes.pop_front();
            if (got.axis_x !== exp_item.axis_x) begin
                $display("%0t: axis_x expected %0d actual %0d", $time,
                         exp_item.axis_x, got.axis_x);
                error_count++;
            end
            if (got.axis_y !== exp_item.axis_y) begin
                $display("%0t: axis_y expected %0d actual %0d", $time,
                         exp_item.axis_y, got.axis_y);
                error_count++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    t_in_item   i_data;
    logic       o_stall;
    logic       o_valid;
    t_out_item  o_data;
    logic       i_stall;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [6:0] i_cfg_data;

    axis_scoreboard board;
    bit long_hold;
    bit sink_quiet;

    joystick_deadzone_normalizer DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("joystick_deadzone_normalizer_tb failed");
        $finish;
    end

    // The task returns at the accepting edge with valid still high; the block
    // is busy from then on, so the next falling edge either drops valid or
    // offers the next item.
    task automatic send_sample(t_in_item it);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_sample(it);
    endtask

    task automatic write_cfg(logic [1:0] index, logic [6:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_register(index, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.expected_axes.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    function automatic t_in_item random_sample();
        t_in_item it;
        it.controller    = 2'($urandom_range(0, 3));
        it.no_controller = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 3))
            0: begin
                it.stick_x = 8'($urandom_range(0, 30) - 15);
                it.stick_y = 8'($urandom_range(0, 30) - 15);
            end
            1: begin
                it.stick_x = 8'($urandom_range(0, 140) - 70);
                it.stick_y = 8'($urandom_range(0, 140) - 70);
            end
            default: begin
                it.stick_x = 8'($urandom());
                it.stick_y = 8'($urandom());
            end
        endcase
        return it;
    endfunction

    // Result side: random stall per transfer, plus one long hold-off window.
    initial begin
        int wait_cycles;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
            end
            wait_cycles = sink_quiet ? 0 : $urandom_range(0, 8);
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            board.check_axes(o_data);
        end
    end

    initial begin
        t_in_item it;
        logic [6:0] starts[4];
        board = new();
        long_hold = 1'b0;
        sink_quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_INNER;
        i_cfg_data = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, dead zone edges, absent controller, renormalization.
        it = '{2'd0, 1'b0, 8'sd0, 8'sd0};          send_sample(it);
        it = '{2'd0, 1'b0, 8'sd5, -8'sd5};         send_sample(it);
        it = '{2'd1, 1'b0, 8'sd6, -8'sd6};         send_sample(it);
        it = '{2'd1, 1'b0, 8'sd7, -8'sd7};         send_sample(it);
        it = '{2'd2, 1'b0, 8'sd127, 8'sd0};        send_sample(it);
        it = '{2'd2, 1'b0, -8'sd128, 8'sd0};       send_sample(it);
        it = '{2'd3, 1'b0, 8'sd127, -8'sd128};     send_sample(it);
        it = '{2'd3, 1'b0, -8'sd128, 8'sd127};     send_sample(it);
        it = '{2'd0, 1'b0, 8'sd40, 8'sd40};        send_sample(it);
        it = '{2'd0, 1'b1, 8'sd100, -8'sd100};     send_sample(it);
        it = '{2'd1, 1'b1, -8'sd1, -8'sd1};        send_sample(it);
        it = '{2'd2, 1'b0, 8'sd48, 8'sd0};         send_sample(it);
        drain();

        // Divisor of two: start range of 32 with widest dead zones.
        write_cfg(CFG_START, 7'd32);
        write_cfg(CFG_INNER, 7'd15);
        write_cfg(CFG_OUTER, 7'd15);
        it = '{2'd0, 1'b0, 8'sd16, 8'sd0};         send_sample(it);
        it = '{2'd0, 1'b0, -8'sd16, 8'sd20};       send_sample(it);
        it = '{2'd1, 1'b0, 8'sd0, 8'sd0};          send_sample(it);
        drain();
        // Unknown index and upper data bits are ignored.
        write_cfg(2'd3, 7'h7F);
        write_cfg(CFG_INNER, 7'h70);
        write_cfg(CFG_OUTER, 7'h70);
        write_cfg(CFG_START, 7'd127);
        it = '{2'd2, 1'b0, 8'sd3, -8'sd1};         send_sample(it);
        it = '{2'd3, 1'b0, -8'sd127, -8'sd127};    send_sample(it);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        long_hold = 1'b1;
        repeat (12) send_sample(random_sample());
        drain();

        starts = '{7'd32, 7'd64, 7'd100, 7'd127};
        for (int phase = 0; phase < 4; phase++) begin
            write_cfg(CFG_INNER, 7'($urandom_range(0, 15)));
            write_cfg(CFG_OUTER, 7'($urandom_range(0, 15)));
            write_cfg(CFG_START, starts[phase]);
            sink_quiet = (phase == 2);
            repeat (340) send_sample(random_sample());
            drain();
        end
        sink_quiet = 1'b0;

        if (board.error_count == 0 && board.expected_axes.size() == 0)
            $display("joystick_deadzone_normalizer_tb passed");
        else
            $display("joystick_deadzone_normalizer_tb failed");
        $finish;
    end

endmodule
